// ===== rtl/assert_macros.svh =====
// Assertion macros used by the encoder datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr, msg)
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// ===== rtl/ibre_pkg.sv =====
// Types and constants shared by the run-length encoder modules.
package ibre_pkg;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [BYTE_W-1:0] LIT_HEADER = 8'h80;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REPEAT = 1'd1;

    // Source of an emitted byte
    typedef enum logic [1:0] {
        SRC_HDR   = 2'd0,
        SRC_LIT   = 2'd1,
        SRC_COUNT = 2'd2,
        SRC_HELD  = 2'd3
    } src_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic load_first;
        logic set_count2;
        logic inc_count;
        logic take_new;
        logic add_lit;
        logic emit;
        src_t src;
        logic idx_clear;
        logic lit_adv;
        logic lit_clear;
        logic fin;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic held_valid;
        logic match;
        logic count_one;
        logic count_ge2;
        logic count_lt_limit;
        logic lit_empty;
        logic lit_full_next;
        logic idx_last;
        logic last;
        logic emit_ok;
    } dp_status_t;

endpackage

// ===== rtl/ibre_in_if.sv =====
// Input byte channel: valid/ready with one source byte and the end marker.
interface ibre_in_if import ibre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              stream_last;

    modport source (output valid, output data_byte, output stream_last, input ready);
    modport sink   (input valid, input data_byte, input stream_last, output ready);
endinterface

// ===== rtl/ibre_out_if.sv =====
// Output code channel: valid/ready with one encoded byte and its flags.
interface ibre_out_if import ibre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              burst_last;
    logic              stream_done;

    modport source (output valid, output code_byte, output burst_last, output stream_done,
                    input ready);
    modport sink   (input valid, input code_byte, input burst_last, input stream_done,
                    output ready);
endinterface

// ===== rtl/ibre_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
interface ibre_cfg_if import ibre_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ibre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ibre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ibre_dp.sv =====
// Encoder datapath: config, held byte and run count, literal buffer, output stage.
`include "assert_macros.svh"

module ibre_dp import ibre_pkg::*; #(
    parameter int MAX_LITERAL = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  stream_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [BYTE_W-1:0]     code_byte,
    output logic                  burst_last,
    output logic                  stream_done,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    localparam int AW = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;
    localparam int CW = $clog2(MAX_LITERAL + 1);

    logic                invert_reg;
    logic [COUNT_W-1:0]  max_rep_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                last_reg;
    logic [BYTE_W-1:0]   held_reg;
    logic                held_valid_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [CW-1:0]       lit_cnt_reg;
    logic [CW-1:0]       idx_reg;
    logic [BYTE_W-1:0]   pend_reg;
    logic                pend_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_bl_reg;
    logic                out_sd_reg;
    logic                out_valid_reg;

    logic [COUNT_W-1:0]  limit;
    logic [CW:0]         lit_cnt_inc;
    logic [CW-1:0]       idx_inc;
    logic                emit_ok;
    logic                do_emit;
    logic                do_fin;
    logic                end_clear;
    logic                out_load;
    logic [AW-1:0]       rd_addr;
    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   emit_byte;

    // Derive limits, flags and handshake permission
    always_comb
    begin
        limit       = (max_rep_reg < 7'd2) ? 7'd2 : max_rep_reg;
        lit_cnt_inc = {1'b0, lit_cnt_reg} + (CW+1)'(1);
        idx_inc     = idx_reg + CW'(1);
        emit_ok     = !pend_valid_reg || !out_valid_reg || out_ready;
        do_emit     = cmd.emit && emit_ok;
        do_fin      = cmd.fin && emit_ok;
        end_clear   = do_fin && last_reg;
        out_load    = (do_emit || do_fin) && pend_valid_reg;
    end

    // Report status to the controller
    always_comb
    begin
        status.held_valid     = held_valid_reg;
        status.match          = held_valid_reg && (byte_reg == held_reg);
        status.count_one      = (count_reg == 7'd1);
        status.count_ge2      = (count_reg >= 7'd2);
        status.count_lt_limit = (count_reg < limit);
        status.lit_empty      = (lit_cnt_reg == '0);
        status.lit_full_next  = (lit_cnt_inc >= (CW+1)'(MAX_LITERAL));
        status.idx_last       = (idx_inc == lit_cnt_reg);
        status.last           = last_reg;
        status.emit_ok        = emit_ok;
    end

    // Read one entry ahead while draining so data is ready for the next beat
    always_comb
    begin
        if (cmd.idx_clear)
        begin
            rd_addr = '0;
        end
        else if (cmd.lit_adv && emit_ok)
        begin
            rd_addr = idx_inc[AW-1:0];
        end
        else
        begin
            rd_addr = idx_reg[AW-1:0];
        end
    end

    ibre_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LITERAL)
    ) u_lit_ram (
        .clk   (clk),
        .we    (cmd.add_lit),
        .waddr (lit_cnt_reg[AW-1:0]),
        .wdata (held_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Select the byte to emit
    always_comb
    begin
        case (cmd.src)
            SRC_HDR:   emit_byte = LIT_HEADER | BYTE_W'(lit_cnt_reg);
            SRC_LIT:   emit_byte = rd_data;
            SRC_COUNT: emit_byte = {1'b0, count_reg};
            SRC_HELD:  emit_byte = held_reg;
            default:   emit_byte = held_reg;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg  <= 1'b1;
            max_rep_reg <= 7'd127;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INVERT:     invert_reg  <= cfg_data[0];
                CFG_MAX_REPEAT: max_rep_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state: run tracking, literal fill, drain index, beat flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= 1'b0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
            lit_cnt_reg    <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                last_reg <= stream_last;
            end

            // Held byte occurrence count
            if (end_clear)
            begin
                held_valid_reg <= 1'b0;
                count_reg      <= '0;
            end
            else if (cmd.load_first)
            begin
                held_valid_reg <= 1'b1;
                count_reg      <= 7'd1;
            end
            else if (cmd.take_new)
            begin
                count_reg <= 7'd1;
            end
            else if (cmd.set_count2)
            begin
                count_reg <= 7'd2;
            end
            else if (cmd.inc_count)
            begin
                count_reg <= count_reg + 7'd1;
            end

            // Literal fill count
            if (end_clear || (cmd.lit_clear && emit_ok))
            begin
                lit_cnt_reg <= '0;
            end
            else if (cmd.add_lit)
            begin
                lit_cnt_reg <= lit_cnt_inc[CW-1:0];
            end

            // Drain index
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.lit_adv && emit_ok)
            begin
                idx_reg <= idx_inc;
            end

            // Pending beat: hold one beat back so the last one can be flagged
            if (do_emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (do_fin)
            begin
                pend_valid_reg <= 1'b0;
            end

            // Output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            byte_reg <= data_byte ^ {BYTE_W{invert_reg}};
        end
        if (cmd.load_first || cmd.take_new)
        begin
            held_reg <= byte_reg;
        end
        if (do_emit)
        begin
            pend_reg <= emit_byte;
        end
        if (out_load)
        begin
            out_byte_reg <= pend_reg;
            out_bl_reg   <= do_fin;
            out_sd_reg   <= do_fin && last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_byte   = out_byte_reg;
    assign burst_last  = out_bl_reg;
    assign stream_done = out_sd_reg;

    `ASSERT_ALWAYS(a_count_tracks_valid, clk, rst_n, held_valid_reg == (count_reg != '0), "run count and held valid disagree")
    `ASSERT_IMPLIES(a_lit_room, clk, rst_n, cmd.add_lit, lit_cnt_reg < CW'(MAX_LITERAL), "literal added to a full buffer")
    `ASSERT_NEXT(a_end_clears, clk, rst_n, end_clear, !held_valid_reg && (lit_cnt_reg == '0) && !pend_valid_reg, "stream end left state behind")

endmodule

// ===== rtl/ibre_ctrl.sv =====
// Encoder controller: sequences each input byte through run, literal and flush steps.
module ibre_ctrl import ibre_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EVAL    = 8'b0000_0010,
        S_LASTCHK = 8'b0000_0100,
        S_FHDR    = 8'b0000_1000,
        S_FDAT    = 8'b0001_0000,
        S_RUNC    = 8'b0010_0000,
        S_RUNV    = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tail_reg;
    logic   tail_next;
    state_t quiet_exit;
    state_t after_flush;

    // Exit targets for the evaluate and literal-data states
    always_comb
    begin
        quiet_exit = status.last ? S_LASTCHK : S_IDLE;
        if (tail_reg)
        begin
            after_flush = status.count_ge2 ? S_RUNC : S_FIN;
        end
        else
        begin
            after_flush = S_LASTCHK;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.src    = SRC_HELD;
        state_next = state_reg;
        tail_next  = tail_reg;
        in_ready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (!status.held_valid)
                begin
                    cmd.load_first = 1'b1;
                    state_next     = quiet_exit;
                end
                else if (status.match && status.count_one)
                begin
                    // Second copy: the pending literal group goes out ahead of the run
                    cmd.set_count2 = 1'b1;
                    state_next     = status.lit_empty ? quiet_exit : S_FHDR;
                end
                else if (status.match && status.count_lt_limit)
                begin
                    cmd.inc_count = 1'b1;
                    state_next    = quiet_exit;
                end
                else if (status.match || status.count_ge2)
                begin
                    // Full run or run broken by a new byte
                    state_next = S_RUNC;
                end
                else
                begin
                    cmd.add_lit  = 1'b1;
                    cmd.take_new = 1'b1;
                    state_next   = status.lit_full_next ? S_FHDR : quiet_exit;
                end
            end

            S_LASTCHK:
            begin
                if (!status.last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    tail_next = 1'b1;
                    if (status.count_ge2)
                    begin
                        state_next = status.lit_empty ? S_RUNC : S_FHDR;
                    end
                    else
                    begin
                        cmd.add_lit = 1'b1;
                        state_next  = S_FHDR;
                    end
                end
            end

            S_FHDR:
            begin
                cmd.emit      = 1'b1;
                cmd.src       = SRC_HDR;
                cmd.idx_clear = 1'b1;
                if (status.emit_ok)
                begin
                    state_next = S_FDAT;
                end
            end

            S_FDAT:
            begin
                cmd.emit      = 1'b1;
                cmd.src       = SRC_LIT;
                cmd.lit_adv   = 1'b1;
                cmd.lit_clear = status.idx_last;
                if (status.emit_ok && status.idx_last)
                begin
                    state_next = after_flush;
                end
            end

            S_RUNC:
            begin
                cmd.emit = 1'b1;
                cmd.src  = SRC_COUNT;
                if (status.emit_ok)
                begin
                    state_next = S_RUNV;
                end
            end

            S_RUNV:
            begin
                cmd.emit = 1'b1;
                cmd.src  = SRC_HELD;
                if (status.emit_ok)
                begin
                    if (tail_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.take_new = 1'b1;
                        state_next   = S_LASTCHK;
                    end
                end
            end

            S_FIN:
            begin
                cmd.fin = 1'b1;
                if (status.emit_ok)
                begin
                    tail_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

// ===== rtl/inverted_byte_rle_encoder.sv =====
// Top level of the inverted byte run-length encoder.
//
// Takes one source byte per beat, optionally complements it, and emits a
// PackBits-style code stream: a run of 2 to max(2, max_repeat) equal bytes
// becomes a count byte and the value, and other bytes gather into literal
// groups of up to MAX_LITERAL bytes sent as 0x80+n and the n bytes. A beat
// with stream_last set flushes everything, empties the run and literal state
// and returns the controller to idle. The block works on one byte at a time:
// it accepts a byte, evaluates it and sends out any codes it produces before
// it accepts the next, and the controller emits at most one beat per cycle,
// while the output accepts, through a one-beat hold stage and the output
// register. A literal flush of n bytes holds the input while n+1 beats go out,
// as the literal buffer is read out one entry per cycle while the output accepts.
// Configuration writes are always taken and must be made while no byte is
// in flight.
module inverted_byte_rle_encoder import ibre_pkg::*; #(
    parameter int MAX_LITERAL = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ibre_in_if.sink      stream,
    ibre_out_if.source   code,
    ibre_cfg_if.sink     cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration writes complete in the cycle they are offered
    assign cfg.ready = 1'b1;

    ibre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ibre_dp #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (stream.data_byte),
        .stream_last (stream.stream_last),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .out_ready   (code.ready),
        .out_valid   (code.valid),
        .code_byte   (code.code_byte),
        .burst_last  (code.burst_last),
        .stream_done (code.stream_done),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
